>>> hw/rtl/top_k_score_tracker_unit_macros.svh
// Assertion helpers shared by the tracker modules. Each expects clk and rst_n in scope.
`ifndef TOP_K_SCORE_TRACKER_UNIT_MACROS_SVH
`define TOP_K_SCORE_TRACKER_UNIT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define TKST_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TKST_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tkst_pkg.sv
package tkst_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int SCORE_BITS_DEF  = 16;

  localparam int OP_BITS   = 2;
  localparam int MM_BITS   = 5;
  localparam int TAG_BITS  = 16;
  localparam int SRC_BITS  = 16;
  localparam int OFS_BITS  = 32;
  localparam int RANK_BITS = 4;
  localparam int PAYLOAD_BITS = TAG_BITS + SRC_BITS + OFS_BITS;

  localparam logic [MM_BITS-1:0] KEEP_COUNT_RESET = 5'd16;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_OFFER  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    RK_PLAIN  = 2'd0,  // clear or readout of an empty table
    RK_OFFER  = 2'd1,  // append or rejected offer
    RK_RESCAN = 2'd2,  // replaced the lowest entry, new minimum found
    RK_ENTRY  = 2'd3   // one ranked entry of a readout
  } res_kind_t;

  typedef struct packed {
    logic      cfg_write;
    logic      clear;
    logic      offer;
    logic      append;
    logic      replace;
    logic      scan_start;
    logic      read_start;
    logic      scan_issue;
    logic      scan_max;
    logic      push;
    logic      commit_min;
    res_kind_t push_kind;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic beats_lowest;
    logic scan_last;
    logic last_rank;
  } sts_t;

endpackage

>>> hw/rtl/tkst_ram.sv
module tkst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tkst_dpath.sv
`include "top_k_score_tracker_unit_macros.svh"

module tkst_dpath #(
  parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
  parameter int SCORE_BITS  = tkst_pkg::SCORE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tkst_pkg::cmd_t                       cmd,
  output tkst_pkg::sts_t                       sts,
  input  logic signed [SCORE_BITS-1:0]         in_score,
  input  logic [tkst_pkg::TAG_BITS-1:0]        in_vector_tag,
  input  logic [tkst_pkg::SRC_BITS-1:0]        in_source_id,
  input  logic [tkst_pkg::OFS_BITS-1:0]        in_text_offset,
  input  logic [tkst_pkg::MM_BITS-1:0]         cfg_keep_count,
  output logic                                 out_accepted,
  output logic                                 out_entry_valid,
  output logic [tkst_pkg::RANK_BITS-1:0]       out_rank,
  output logic signed [SCORE_BITS-1:0]         out_score,
  output logic [tkst_pkg::TAG_BITS-1:0]        out_vector_tag,
  output logic [tkst_pkg::SRC_BITS-1:0]        out_source_id,
  output logic [tkst_pkg::OFS_BITS-1:0]        out_text_offset,
  output logic                                 out_last
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (HW > tkst_pkg::MM_BITS) ? HW : tkst_pkg::MM_BITS;
  localparam int EW = SCORE_BITS + tkst_pkg::PAYLOAD_BITS;
  localparam int TW = tkst_pkg::TAG_BITS;
  localparam int SW = tkst_pkg::SRC_BITS;
  localparam int OW = tkst_pkg::OFS_BITS;
  localparam int RB = tkst_pkg::RANK_BITS;
  localparam logic signed [SCORE_BITS-1:0] SCORE_MAXPOS = {1'b0, {(SCORE_BITS-1){1'b1}}};

  logic [tkst_pkg::MM_BITS-1:0] keep_count_r;
  logic [HW-1:0]                held_r;
  logic [IW-1:0]                lowest_slot_r;
  logic signed [SCORE_BITS-1:0] lowest_score_r;
  logic                         acc_r;
  logic [IW-1:0]                scan_idx_r;
  logic                         rd_vld_r;
  logic [IW-1:0]                rd_idx_r;
  logic                         found_r;
  logic [IW-1:0]                best_idx_r;
  logic signed [SCORE_BITS-1:0] best_score_r;
  logic [TW-1:0]                best_tag_r;
  logic [SW-1:0]                best_src_r;
  logic [OW-1:0]                best_ofs_r;
  logic [TABLE_DEPTH-1:0]       taken_r;
  logic [IW-1:0]                rank_r;

  logic                         out_accepted_r;
  logic                         out_entry_valid_r;
  logic [RB-1:0]                out_rank_r;
  logic signed [SCORE_BITS-1:0] out_score_r;
  logic [TW-1:0]                out_vector_tag_r;
  logic [SW-1:0]                out_source_id_r;
  logic [OW-1:0]                out_text_offset_r;
  logic                         out_last_r;

  logic [CW-1:0]                mm_ext;
  logic [HW-1:0]                lim;
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  logic [EW-1:0]                ram_wdata;
  logic [EW-1:0]                ram_rdata;
  logic signed [SCORE_BITS-1:0] rd_score;
  logic [TW-1:0]                rd_tag;
  logic [SW-1:0]                rd_src;
  logic [OW-1:0]                rd_ofs;
  logic                         rd_better;
  logic                         upd;
  logic [IW+RB-1:0]             rank_ext;

  // Effective limit: keep count clipped to 1..TABLE_DEPTH
  assign mm_ext = CW'(keep_count_r);
  always_comb begin
    if (mm_ext == '0) begin
      lim = HW'(1);
    end else if (mm_ext > CW'(TABLE_DEPTH)) begin
      lim = HW'(TABLE_DEPTH);
    end else begin
      lim = mm_ext[HW-1:0];
    end
  end

  assign sts.full         = held_r >= lim;
  assign sts.empty        = held_r == '0;
  assign sts.beats_lowest = in_score > lowest_score_r;
  assign sts.scan_last    = (HW'(scan_idx_r) + HW'(1)) == held_r;
  assign sts.last_rank    = (HW'(rank_r) + HW'(1)) == held_r;

  assign ram_we    = cmd.append || cmd.replace;
  assign ram_waddr = cmd.append ? held_r[IW-1:0] : lowest_slot_r;
  assign ram_wdata = {in_score, in_vector_tag, in_source_id, in_text_offset};

  tkst_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx_r),
    .rdata(ram_rdata)
  );

  assign rd_score = $signed(ram_rdata[EW-1 -: SCORE_BITS]);
  assign rd_tag   = ram_rdata[OW+SW +: TW];
  assign rd_src   = ram_rdata[OW +: SW];
  assign rd_ofs   = ram_rdata[OW-1:0];

  // Max scan skips entries already read out; ties keep the lower slot
  always_comb begin
    if (cmd.scan_max) begin
      rd_better = !taken_r[rd_idx_r] && (!found_r || (rd_score > best_score_r));
    end else begin
      rd_better = !found_r || (rd_score < best_score_r);
    end
  end
  assign upd = rd_vld_r && rd_better;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r   <= tkst_pkg::KEEP_COUNT_RESET;
      held_r         <= '0;
      lowest_slot_r  <= '0;
      lowest_score_r <= SCORE_MAXPOS;
      scan_idx_r     <= '0;
      rd_vld_r       <= 1'b0;
      found_r        <= 1'b0;
      taken_r        <= '0;
      rank_r         <= '0;
    end else begin
      rd_vld_r <= cmd.scan_issue;
      if (cmd.cfg_write) begin
        keep_count_r <= cfg_keep_count;
      end
      if (cmd.cfg_write || cmd.clear) begin
        held_r         <= '0;
        lowest_slot_r  <= '0;
        lowest_score_r <= SCORE_MAXPOS;
      end
      if (cmd.append) begin
        held_r <= held_r + HW'(1);
        if (in_score < lowest_score_r) begin
          lowest_score_r <= in_score;
          lowest_slot_r  <= held_r[IW-1:0];
        end
      end
      if (cmd.commit_min) begin
        lowest_slot_r  <= best_idx_r;
        lowest_score_r <= best_score_r;
      end
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx_r <= scan_idx_r + IW'(1);
      end
      if (cmd.scan_start) begin
        found_r <= 1'b0;
      end else if (upd) begin
        found_r <= 1'b1;
      end
      if (cmd.read_start) begin
        taken_r <= '0;
        rank_r  <= '0;
      end else if (cmd.push && (cmd.push_kind == tkst_pkg::RK_ENTRY)) begin
        taken_r[best_idx_r] <= 1'b1;
        rank_r              <= rank_r + IW'(1);
      end
    end
  end

  assign rank_ext = {{RB{1'b0}}, rank_r};

  always_ff @(posedge clk) begin
    if (cmd.offer) begin
      acc_r <= !sts.full;
    end
    if (cmd.scan_issue) begin
      rd_idx_r <= scan_idx_r;
    end
    if (upd) begin
      best_idx_r   <= rd_idx_r;
      best_score_r <= rd_score;
      best_tag_r   <= rd_tag;
      best_src_r   <= rd_src;
      best_ofs_r   <= rd_ofs;
    end
    if (cmd.push) begin
      out_accepted_r    <= 1'b0;
      out_entry_valid_r <= 1'b0;
      out_rank_r        <= '0;
      out_score_r       <= '0;
      out_vector_tag_r  <= '0;
      out_source_id_r   <= '0;
      out_text_offset_r <= '0;
      out_last_r        <= 1'b1;
      unique case (cmd.push_kind)
        tkst_pkg::RK_PLAIN: begin
        end
        tkst_pkg::RK_OFFER: begin
          out_accepted_r <= acc_r;
        end
        tkst_pkg::RK_RESCAN: begin
          out_accepted_r <= 1'b1;
        end
        tkst_pkg::RK_ENTRY: begin
          out_entry_valid_r <= 1'b1;
          out_rank_r        <= rank_ext[RB-1:0];
          out_score_r       <= best_score_r;
          out_vector_tag_r  <= best_tag_r;
          out_source_id_r   <= best_src_r;
          out_text_offset_r <= best_ofs_r;
          out_last_r        <= sts.last_rank;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_accepted    = out_accepted_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_rank        = out_rank_r;
  assign out_score       = out_score_r;
  assign out_vector_tag  = out_vector_tag_r;
  assign out_source_id   = out_source_id_r;
  assign out_text_offset = out_text_offset_r;
  assign out_last        = out_last_r;

  `TKST_ASSERT_ALWAYS(a_held_in_limit, held_r <= lim, "held count exceeds limit")
  `TKST_ASSERT_IMPLY(a_lowest_held, held_r != '0, HW'(lowest_slot_r) < held_r, "lowest slot not held")

endmodule

>>> hw/rtl/tkst_ctrl.sv
`include "top_k_score_tracker_unit_macros.svh"

module tkst_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tkst_pkg::OP_BITS-1:0]  in_operation,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tkst_pkg::cmd_t                cmd,
  input  tkst_pkg::sts_t                sts
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_PUSH  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  tkst_pkg::res_kind_t kind_r, kind_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = state_r != ST_IDLE;
  assign cfg_ready = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.scan_max  = kind_r == tkst_pkg::RK_ENTRY;
    cmd.push_kind = kind_r;
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        cmd.cfg_write = cfg_valid;
        if (in_valid) begin
          unique case (in_operation)
            tkst_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
              kind_nxt  = tkst_pkg::RK_PLAIN;
              state_nxt = ST_PUSH;
            end
            tkst_pkg::OP_OFFER: begin
              cmd.offer = 1'b1;
              if (!sts.full) begin
                cmd.append = 1'b1;
                kind_nxt   = tkst_pkg::RK_OFFER;
                state_nxt  = ST_PUSH;
              end else if (sts.beats_lowest) begin
                // overwrite the lowest slot, then rescan for the new minimum
                cmd.replace    = 1'b1;
                cmd.scan_start = 1'b1;
                kind_nxt       = tkst_pkg::RK_RESCAN;
                state_nxt      = ST_SCAN;
              end else begin
                kind_nxt  = tkst_pkg::RK_OFFER;
                state_nxt = ST_PUSH;
              end
            end
            tkst_pkg::OP_READ: begin
              if (sts.empty) begin
                kind_nxt  = tkst_pkg::RK_PLAIN;
                state_nxt = ST_PUSH;
              end else begin
                cmd.read_start = 1'b1;
                cmd.scan_start = 1'b1;
                kind_nxt       = tkst_pkg::RK_ENTRY;
                state_nxt      = ST_SCAN;
              end
            end
            tkst_pkg::OP_UNUSED: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data is compared this cycle
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          cmd.push       = 1'b1;
          cmd.commit_min = kind_r == tkst_pkg::RK_RESCAN;
          out_valid_nxt  = 1'b1;
          if ((kind_r == tkst_pkg::RK_ENTRY) && !sts.last_rank) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= tkst_pkg::RK_PLAIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TKST_ASSERT_IMPLY(a_push_slot_free, cmd.push, slot_free, "result loaded over a pending transfer")
  `TKST_ASSERT_IMPLY(a_scan_nonempty, state_r == ST_SCAN, !sts.empty, "scan over an empty table")

endmodule

>>> hw/rtl/top_k_score_tracker_unit.sv
// Top-K score tracker. Holds the best keep-count candidates (score plus tag, source id and
// text offset) in a TABLE_DEPTH-entry RAM with one registered read port. An offer that
// replaces the lowest entry rescans the held entries for the new minimum, one slot per
// cycle. In a readout, each rank is a full pass over the held entries for the highest entry
// not yet emitted, and the next pass runs while the previous result waits for its transfer.
// An empty readout gives one result with entry_valid low. Writing the keep count empties the
// table; write it only while no operation is in flight.
module top_k_score_tracker_unit #(
  parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
  parameter int SCORE_BITS  = tkst_pkg::SCORE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tkst_pkg::OP_BITS-1:0]       in_operation,
  input  logic signed [SCORE_BITS-1:0]       in_score,
  input  logic [tkst_pkg::TAG_BITS-1:0]      in_vector_tag,
  input  logic [tkst_pkg::SRC_BITS-1:0]      in_source_id,
  input  logic [tkst_pkg::OFS_BITS-1:0]      in_text_offset,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tkst_pkg::MM_BITS-1:0]       cfg_keep_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_accepted,
  output logic                               out_entry_valid,
  output logic [tkst_pkg::RANK_BITS-1:0]     out_rank,
  output logic signed [SCORE_BITS-1:0]       out_score,
  output logic [tkst_pkg::TAG_BITS-1:0]      out_vector_tag,
  output logic [tkst_pkg::SRC_BITS-1:0]      out_source_id,
  output logic [tkst_pkg::OFS_BITS-1:0]      out_text_offset,
  output logic                               out_last
);

  tkst_pkg::cmd_t cmd;
  tkst_pkg::sts_t sts;

  tkst_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  tkst_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .SCORE_BITS (SCORE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_score       (in_score),
    .in_vector_tag  (in_vector_tag),
    .in_source_id   (in_source_id),
    .in_text_offset (in_text_offset),
    .cfg_keep_count (cfg_keep_count),
    .out_accepted   (out_accepted),
    .out_entry_valid(out_entry_valid),
    .out_rank       (out_rank),
    .out_score      (out_score),
    .out_vector_tag (out_vector_tag),
    .out_source_id  (out_source_id),
    .out_text_offset(out_text_offset),
    .out_last       (out_last)
  );

endmodule

>>> sim/top_k_table_checker.sv
module top_k_table_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic [tkst_pkg::OP_BITS-1:0]            in_operation,
  input  logic signed [tkst_pkg::SCORE_BITS_DEF-1:0] in_score,
  input  logic [tkst_pkg::TAG_BITS-1:0]           in_vector_tag,
  input  logic [tkst_pkg::SRC_BITS-1:0]           in_source_id,
  input  logic [tkst_pkg::OFS_BITS-1:0]           in_text_offset,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [tkst_pkg::MM_BITS-1:0]            cfg_keep_count,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic                                    out_accepted,
  input  logic                                    out_entry_valid,
  input  logic [tkst_pkg::RANK_BITS-1:0]          out_rank,
  input  logic signed [tkst_pkg::SCORE_BITS_DEF-1:0] out_score,
  input  logic [tkst_pkg::TAG_BITS-1:0]           out_vector_tag,
  input  logic [tkst_pkg::SRC_BITS-1:0]           out_source_id,
  input  logic [tkst_pkg::OFS_BITS-1:0]           out_text_offset,
  input  logic                                    out_last,
  output int                                      mismatch_count,
  output int                                      results_due
);
  import tkst_pkg::*;

  localparam int SCORE_W = SCORE_BITS_DEF;
  localparam int DEPTH   = TABLE_DEPTH_DEF;
  localparam logic signed [SCORE_W-1:0] TOP_SCORE = {1'b0, {(SCORE_W-1){1'b1}}};

  typedef struct packed {
    logic                     accepted;
    logic                     entry_valid;
    logic [RANK_BITS-1:0]     rank;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_BITS-1:0]      vector_tag;
    logic [SRC_BITS-1:0]      source_id;
    logic [OFS_BITS-1:0]      text_offset;
    logic                     last;
  } ranked_result_t;

  logic signed [SCORE_W-1:0] held_score [DEPTH];
  logic [TAG_BITS-1:0]       held_tag [DEPTH];
  logic [SRC_BITS-1:0]       held_source [DEPTH];
  logic [OFS_BITS-1:0]       held_offset [DEPTH];
  int                        held_count;
  int                        lowest_slot;
  logic signed [SCORE_W-1:0] lowest_score;
  logic [MM_BITS-1:0]        keep_count;
  ranked_result_t            ranked_results_q[$];

  function automatic int keep_limit();
    int m;
    m = keep_count;
    if (m < 1) m = 1;
    if (m > DEPTH) m = DEPTH;
    return m;
  endfunction

  function automatic void empty_table();
    held_count   = 0;
    lowest_slot  = 0;
    lowest_score = TOP_SCORE;
  endfunction

  function automatic void expect_result(ranked_result_t res);
    ranked_results_q = {ranked_results_q, res};
  endfunction

  function automatic void put_slot(int idx, logic signed [SCORE_W-1:0] sc,
                                   logic [TAG_BITS-1:0] tag, logic [SRC_BITS-1:0] src,
                                   logic [OFS_BITS-1:0] ofs);
    held_score[idx]  = sc;
    held_tag[idx]    = tag;
    held_source[idx] = src;
    held_offset[idx] = ofs;
  endfunction

  function automatic bit offer_candidate(logic signed [SCORE_W-1:0] sc,
                                         logic [TAG_BITS-1:0] tag,
                                         logic [SRC_BITS-1:0] src,
                                         logic [OFS_BITS-1:0] ofs);
    int i;
    if (held_count >= keep_limit()) begin
      // full: only a strictly higher score evicts the minimum
      if (sc <= lowest_score) return 1'b0;
      put_slot(lowest_slot, sc, tag, src, ofs);
      lowest_slot  = 0;
      lowest_score = held_score[0];
      for (i = 1; i < held_count; i++) begin
        if (held_score[i] < lowest_score) begin
          lowest_score = held_score[i];
          lowest_slot  = i;
        end
      end
      return 1'b1;
    end
    put_slot(held_count, sc, tag, src, ofs);
    if (sc < lowest_score) begin
      lowest_score = sc;
      lowest_slot  = held_count;
    end
    held_count++;
    return 1'b1;
  endfunction

  function automatic void rank_table();
    bit             taken [DEPTH];
    int             best;
    ranked_result_t res;
    taken = '{default: 1'b0};
    if (held_count == 0) begin
      res      = '0;
      res.last = 1'b1;
      expect_result(res);
      return;
    end
    for (int r = 0; r < held_count; r++) begin
      best = -1;
      // strict compare keeps the lowest slot on ties
      for (int i = 0; i < held_count; i++) begin
        if (!taken[i] && (best < 0 || held_score[i] > held_score[best])) best = i;
      end
      taken[best]     = 1'b1;
      res             = '0;
      res.entry_valid = 1'b1;
      res.rank        = r[RANK_BITS-1:0];
      res.score       = held_score[best];
      res.vector_tag  = held_tag[best];
      res.source_id   = held_source[best];
      res.text_offset = held_offset[best];
      res.last        = (r == held_count - 1);
      expect_result(res);
    end
  endfunction

  function automatic void predict_tracker_step();
    ranked_result_t res;
    res = '0;
    case (in_operation)
      OP_CLEAR: begin
        empty_table();
        res.last = 1'b1;
        expect_result(res);
      end
      OP_OFFER: begin
        res.accepted = offer_candidate(in_score, in_vector_tag, in_source_id, in_text_offset);
        res.last     = 1'b1;
        expect_result(res);
      end
      OP_READ: rank_table();
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    ranked_result_t exp_res;
    if (!rst_n) begin
      keep_count     = KEEP_COUNT_RESET;
      empty_table();
      ranked_results_q.delete();
      mismatch_count = 0;
    end else begin
      // results first: an item accepted at this edge cannot have produced one yet
      if (out_valid && !out_stall) begin
        if (ranked_results_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, score %h, last %b",
                   $time, out_score, out_last);
          mismatch_count++;
        end else begin
          exp_res = ranked_results_q.pop_front();
          check_field("accepted", exp_res.accepted, out_accepted);
          check_field("entry_valid", exp_res.entry_valid, out_entry_valid);
          check_field("rank", exp_res.rank, out_rank);
          check_field("score", exp_res.score, out_score);
          check_field("vector_tag", exp_res.vector_tag, out_vector_tag);
          check_field("source_id", exp_res.source_id, out_source_id);
          check_field("text_offset", exp_res.text_offset, out_text_offset);
          check_field("last", exp_res.last, out_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        keep_count = cfg_keep_count;
        empty_table();
      end
      if (in_valid && !in_stall) predict_tracker_step();
    end
    results_due = ranked_results_q.size();
  end

endmodule

>>> sim/top_k_score_tracker_unit_test.sv
module top_k_score_tracker_unit_test;
  import tkst_pkg::*;

  localparam int SCORE_W       = SCORE_BITS_DEF;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 24;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [OP_BITS-1:0]        in_operation;
  logic signed [SCORE_W-1:0] in_score;
  logic [TAG_BITS-1:0]       in_vector_tag;
  logic [SRC_BITS-1:0]       in_source_id;
  logic [OFS_BITS-1:0]       in_text_offset;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [MM_BITS-1:0]        cfg_keep_count;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_accepted;
  logic                      out_entry_valid;
  logic [RANK_BITS-1:0]      out_rank;
  logic signed [SCORE_W-1:0] out_score;
  logic [TAG_BITS-1:0]       out_vector_tag;
  logic [SRC_BITS-1:0]       out_source_id;
  logic [OFS_BITS-1:0]       out_text_offset;
  logic                      out_last;

  int mismatch_count;
  int results_due;
  int quiet_cycles;
  bit steady;

  top_k_score_tracker_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_score        (in_score),
    .in_vector_tag   (in_vector_tag),
    .in_source_id    (in_source_id),
    .in_text_offset  (in_text_offset),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_keep_count  (cfg_keep_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_entry_valid (out_entry_valid),
    .out_rank        (out_rank),
    .out_score       (out_score),
    .out_vector_tag  (out_vector_tag),
    .out_source_id   (out_source_id),
    .out_text_offset (out_text_offset),
    .out_last        (out_last)
  );

  top_k_table_checker ranking_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_score        (in_score),
    .in_vector_tag   (in_vector_tag),
    .in_source_id    (in_source_id),
    .in_text_offset  (in_text_offset),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_keep_count  (cfg_keep_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_entry_valid (out_entry_valid),
    .out_rank        (out_rank),
    .out_score       (out_score),
    .out_vector_tag  (out_vector_tag),
    .out_source_id   (out_source_id),
    .out_text_offset (out_text_offset),
    .out_last        (out_last),
    .mismatch_count  (mismatch_count),
    .results_due     (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = !steady && ($urandom_range(99) < 27);
    end
  end

  // end the run once nothing has moved on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("top_k_score_tracker_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(logic [OP_BITS-1:0] op, logic signed [SCORE_W-1:0] sc,
                           logic [TAG_BITS-1:0] tag, logic [SRC_BITS-1:0] src,
                           logic [OFS_BITS-1:0] ofs);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_operation   = op;
    in_score       = sc;
    in_vector_tag  = tag;
    in_source_id   = src;
    in_text_offset = ofs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random(logic [OP_BITS-1:0] op, logic signed [SCORE_W-1:0] sc);
    send_item(op, sc, TAG_BITS'($urandom), SRC_BITS'($urandom), OFS_BITS'($urandom));
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(3))
      0: return SCORE_W'($urandom_range(8) - 4);
      1: return $urandom_range(1) ? {1'b0, {(SCORE_W-1){1'b1}}} : {1'b1, {(SCORE_W-1){1'b0}}};
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  task automatic offer_random();
    send_random(OP_OFFER, pick_score());
  endtask

  // drain every result, then give the block time to finish silent work
  task automatic settle();
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_keep_count(logic [MM_BITS-1:0] value);
    cfg_valid      = 1'b1;
    cfg_keep_count = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_search_phase(logic [MM_BITS-1:0] setting, int budget);
    int sent;
    int lim;
    int offers;
    lim = (setting == 0) ? 1 : (setting > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : setting;
    settle();
    write_keep_count(setting);
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 80) begin
        // optionally clear, offer up to four past the limit, rank
        if ($urandom_range(1)) begin
          send_random(OP_CLEAR, SCORE_W'($urandom));
          sent++;
        end
        offers = $urandom_range(1, lim + 4);
        repeat (offers) offer_random();
        send_random(OP_READ, SCORE_W'($urandom));
        sent += offers + 1;
      end else begin
        send_random(OP_BITS'($urandom_range(3)), pick_score());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    steady          = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_CLEAR;
    in_score        = '0;
    in_vector_tag   = '0;
    in_source_id    = '0;
    in_text_offset  = '0;
    cfg_valid       = 1'b0;
    cfg_keep_count  = KEEP_COUNT_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset setting: empty readout, field extremes, unused code, clear
    send_item(OP_READ, '0, '0, '0, '0);
    send_item(OP_OFFER, 16'sh7fff, '1, '1, '1);
    send_item(OP_OFFER, 16'sh8000, '0, '0, '0);
    send_random(OP_UNUSED, SCORE_W'($urandom));
    send_item(OP_READ, '1, '1, '1, '1);
    send_item(OP_CLEAR, '1, '1, '1, '1);
    send_item(OP_READ, '0, '0, '0, '0);

    // zero keeps one entry: a tie is rejected, a higher score replaces
    settle();
    write_keep_count(5'd0);
    send_item(OP_OFFER, 16'sd5, 16'h0001, 16'h0101, 32'h0000_0001);
    send_item(OP_OFFER, 16'sd5, 16'h0002, 16'h0202, 32'h0000_0002);
    send_item(OP_OFFER, 16'sd6, 16'h0003, 16'h0303, 32'h0000_0003);
    send_item(OP_OFFER, 16'sh8000, 16'h0004, 16'h0404, 32'h0000_0004);
    send_item(OP_READ, '0, '0, '0, '0);

    // equal scores: evict the lowest slot, rank ties lowest slot first
    settle();
    write_keep_count(5'd3);
    send_item(OP_OFFER, 16'sd10, 16'h00a1, 16'h0011, 32'hdead_0001);
    send_item(OP_OFFER, 16'sd10, 16'h00a2, 16'h0022, 32'hdead_0002);
    send_item(OP_OFFER, 16'sd10, 16'h00a3, 16'h0033, 32'hdead_0003);
    send_item(OP_OFFER, 16'sd20, 16'h00a4, 16'h0044, 32'hdead_0004);
    send_item(OP_OFFER, 16'sd10, 16'h00a5, 16'h0055, 32'hdead_0005);
    send_item(OP_READ, '0, '0, '0, '0);

    run_search_phase(5'd16, 12);
    run_search_phase(5'd1, 12);
    steady = 1'b1;
    run_search_phase(5'd31, 14);
    steady = 1'b0;
    run_search_phase(5'd5, 12);
    run_search_phase(5'd2, 12);
    run_search_phase(5'd16, 12);

    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("top_k_score_tracker_unit test passed");
    end else begin
      $display("top_k_score_tracker_unit test failed");
    end
    $finish;
  end

endmodule
